FILE: rtl/pi_branch_current_power_macros.svh
// Assertion macros shared by the pi-model branch RTL.
// Used by the top level; no other dependencies.
`ifndef PI_BRANCH_CURRENT_POWER_MACROS_SVH
`define PI_BRANCH_CURRENT_POWER_MACROS_SVH

`ifndef SYNTHESIS
`define PBCP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBCP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBCP_ASSERT(label, clk, rst, prop, msg)
`define PBCP_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

FILE: rtl/pbcp_pkg.sv
// Shared widths, types and the saturation function of the pi-model branch block.
// No dependencies; used by every module of the block.
`default_nettype none

package pbcp_pkg;

   localparam int VOLT_W      = 16;              // Q4.12 voltage
   localparam int CUR_W       = 32;              // Q16.16 admittance, current, power
   localparam int DIFF_W      = VOLT_W + 1;      // voltage difference
   localparam int YPROD_W     = CUR_W + DIFF_W;  // admittance times difference
   localparam int SPROD_W     = CUR_W + VOLT_W;  // admittance or current times voltage
   localparam int ACC_W       = YPROD_W + 1;     // series current term
   localparam int SHUNT_W     = SPROD_W + 1;     // shunt term with rounding offset
   localparam int SUM_W       = ACC_W + 1;       // full current sum before rounding
   localparam int PSUM_W      = SPROD_W + 2;     // power sum with rounding offset
   localparam int LOSS_W      = CUR_W + 1;       // sum of two end powers
   localparam int ROUND_SHIFT = 12;
   localparam int RND_HALF    = 2 ** (ROUND_SHIFT - 1);
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERIES_G   = 2'd0,
      CSR_SERIES_B   = 2'd1,
      CSR_HALF_SHUNT = 2'd2
   } pbcp_csr_type;

   // Handshake state that travels with one pipeline stage.
   typedef struct packed {
      logic valid;
      logic clip;
   } pbcp_flow_type;

   typedef struct packed {
      logic [VOLT_W-1:0] v2i;
      logic [VOLT_W-1:0] v2r;
      logic [VOLT_W-1:0] v1i;
      logic [VOLT_W-1:0] v1r;
   } pbcp_volt_type;

   typedef struct packed {
      logic [CUR_W-1:0] i2i;
      logic [CUR_W-1:0] i2r;
      logic [CUR_W-1:0] i1i;
      logic [CUR_W-1:0] i1r;
   } pbcp_cur_type;

   typedef struct packed {
      logic [CUR_W-1:0] li;
      logic [CUR_W-1:0] lr;
      logic [CUR_W-1:0] s2i;
      logic [CUR_W-1:0] s2r;
      logic [CUR_W-1:0] s1i;
      logic [CUR_W-1:0] s1r;
   } pbcp_pow_type;

   typedef struct packed {
      logic             clip;
      logic [CUR_W-1:0] value;
   } pbcp_sat_type;

   // Clip a wide signed value to 32 bits; the value fits when all bits from
   // the 32-bit sign bit upward agree.
   function automatic pbcp_sat_type sat32(input logic signed [SUM_W-1:0] x);
      pbcp_sat_type r;
      if ((x[SUM_W-1:CUR_W-1] == '0) || (x[SUM_W-1:CUR_W-1] == '1)) begin
         r.clip  = 1'b0;
         r.value = x[CUR_W-1:0];
      end else begin
         r.clip  = 1'b1;
         r.value = x[SUM_W-1] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pbcp_current.sv
// End-current pipeline of the pi-model branch: five register stages.
// Depends on pbcp_pkg.
`default_nettype none

module pbcp_current (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  pbcp_pkg::pbcp_flow_type        flow_in,
   input  pbcp_pkg::pbcp_volt_type        volt_in,
   input  logic [pbcp_pkg::CUR_W-1:0]     series_g,
   input  logic [pbcp_pkg::CUR_W-1:0]     series_b,
   input  logic [pbcp_pkg::CUR_W-1:0]     half_shunt,
   output pbcp_pkg::pbcp_flow_type        flow_out,
   output pbcp_pkg::pbcp_volt_type        volt_out,
   output pbcp_pkg::pbcp_cur_type         cur_out
);

   // Stage 1: voltage difference across the series branch.
   logic                                   s1_valid_ff;
   pbcp_pkg::pbcp_volt_type                s1_volt_ff;
   logic signed [pbcp_pkg::DIFF_W-1:0]     s1_dr_ff, s1_dr_in;
   logic signed [pbcp_pkg::DIFF_W-1:0]     s1_di_ff, s1_di_in;

   // Stage 2: series and shunt products.
   logic                                   s2_valid_ff;
   pbcp_pkg::pbcp_volt_type                s2_volt_ff;
   logic signed [pbcp_pkg::YPROD_W-1:0]    s2_gdr_ff, s2_bdi_ff, s2_gdi_ff, s2_bdr_ff;
   logic signed [pbcp_pkg::SPROD_W-1:0]    s2_h1r_ff, s2_h1i_ff, s2_h2r_ff, s2_h2i_ff;

   // Stage 3: series current terms and shunt terms with the rounding offset.
   logic                                   s3_valid_ff;
   pbcp_pkg::pbcp_volt_type                s3_volt_ff;
   logic signed [pbcp_pkg::ACC_W-1:0]      s3_a_ff, s3_b_ff;
   logic signed [pbcp_pkg::SHUNT_W-1:0]    s3_c1r_ff, s3_c1i_ff, s3_c2r_ff, s3_c2i_ff;

   // Stage 4: full current sums in Q.28.
   logic                                   s4_valid_ff;
   pbcp_pkg::pbcp_volt_type                s4_volt_ff;
   logic signed [pbcp_pkg::SUM_W-1:0]      s4_x1r_ff, s4_x1i_ff, s4_x2r_ff, s4_x2i_ff;

   // Stage 5: rounded and clipped currents.
   logic                                   s5_valid_ff;
   logic                                   s5_clip_ff, s5_clip_in;
   pbcp_pkg::pbcp_volt_type                s5_volt_ff;
   pbcp_pkg::pbcp_cur_type                 s5_cur_ff, s5_cur_in;

   logic signed [pbcp_pkg::CUR_W-1:0]      g_s, b_s, h_s;
   pbcp_pkg::pbcp_sat_type                 sat_1r, sat_1i, sat_2r, sat_2i;

   assign g_s = $signed(series_g);
   assign b_s = $signed(series_b);
   assign h_s = $signed(half_shunt);

   assign s1_dr_in = $signed({volt_in.v1r[pbcp_pkg::VOLT_W-1], volt_in.v1r})
                   - $signed({volt_in.v2r[pbcp_pkg::VOLT_W-1], volt_in.v2r});
   assign s1_di_in = $signed({volt_in.v1i[pbcp_pkg::VOLT_W-1], volt_in.v1i})
                   - $signed({volt_in.v2i[pbcp_pkg::VOLT_W-1], volt_in.v2i});

   always_comb begin
      sat_1r = pbcp_pkg::sat32(s4_x1r_ff >>> pbcp_pkg::ROUND_SHIFT);
      sat_1i = pbcp_pkg::sat32(s4_x1i_ff >>> pbcp_pkg::ROUND_SHIFT);
      sat_2r = pbcp_pkg::sat32(s4_x2r_ff >>> pbcp_pkg::ROUND_SHIFT);
      sat_2i = pbcp_pkg::sat32(s4_x2i_ff >>> pbcp_pkg::ROUND_SHIFT);
      s5_cur_in.i1r = sat_1r.value;
      s5_cur_in.i1i = sat_1i.value;
      s5_cur_in.i2r = sat_2r.value;
      s5_cur_in.i2i = sat_2i.value;
      s5_clip_in = sat_1r.clip | sat_1i.clip | sat_2r.clip | sat_2i.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= flow_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_volt_ff <= volt_in;
         s1_dr_ff   <= s1_dr_in;
         s1_di_ff   <= s1_di_in;

         s2_volt_ff <= s1_volt_ff;
         s2_gdr_ff  <= g_s * s1_dr_ff;
         s2_bdi_ff  <= b_s * s1_di_ff;
         s2_gdi_ff  <= g_s * s1_di_ff;
         s2_bdr_ff  <= b_s * s1_dr_ff;
         s2_h1r_ff  <= h_s * $signed(s1_volt_ff.v1r);
         s2_h1i_ff  <= h_s * $signed(s1_volt_ff.v1i);
         s2_h2r_ff  <= h_s * $signed(s1_volt_ff.v2r);
         s2_h2i_ff  <= h_s * $signed(s1_volt_ff.v2i);

         // The series term y*(V1-V2) enters I1 with plus and I2 with minus.
         s3_volt_ff <= s2_volt_ff;
         s3_a_ff    <= pbcp_pkg::ACC_W'(s2_gdr_ff) - pbcp_pkg::ACC_W'(s2_bdi_ff);
         s3_b_ff    <= pbcp_pkg::ACC_W'(s2_gdi_ff) + pbcp_pkg::ACC_W'(s2_bdr_ff);
         s3_c1r_ff  <= pbcp_pkg::SHUNT_W'(pbcp_pkg::RND_HALF) - pbcp_pkg::SHUNT_W'(s2_h1i_ff);
         s3_c1i_ff  <= pbcp_pkg::SHUNT_W'(pbcp_pkg::RND_HALF) + pbcp_pkg::SHUNT_W'(s2_h1r_ff);
         s3_c2r_ff  <= pbcp_pkg::SHUNT_W'(pbcp_pkg::RND_HALF) - pbcp_pkg::SHUNT_W'(s2_h2i_ff);
         s3_c2i_ff  <= pbcp_pkg::SHUNT_W'(pbcp_pkg::RND_HALF) + pbcp_pkg::SHUNT_W'(s2_h2r_ff);

         s4_volt_ff <= s3_volt_ff;
         s4_x1r_ff  <= pbcp_pkg::SUM_W'(s3_a_ff) + pbcp_pkg::SUM_W'(s3_c1r_ff);
         s4_x1i_ff  <= pbcp_pkg::SUM_W'(s3_b_ff) + pbcp_pkg::SUM_W'(s3_c1i_ff);
         s4_x2r_ff  <= pbcp_pkg::SUM_W'(s3_c2r_ff) - pbcp_pkg::SUM_W'(s3_a_ff);
         s4_x2i_ff  <= pbcp_pkg::SUM_W'(s3_c2i_ff) - pbcp_pkg::SUM_W'(s3_b_ff);

         s5_volt_ff <= s4_volt_ff;
         s5_cur_ff  <= s5_cur_in;
         s5_clip_ff <= s5_clip_in;
      end
   end

   assign flow_out.valid = s5_valid_ff;
   assign flow_out.clip  = s5_clip_ff;
   assign volt_out       = s5_volt_ff;
   assign cur_out        = s5_cur_ff;

endmodule

`default_nettype wire

FILE: rtl/pbcp_power.sv
// End-power and loss pipeline of the pi-model branch: four register stages,
// the last one being the result register. Depends on pbcp_pkg.
`default_nettype none

module pbcp_power (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  pbcp_pkg::pbcp_flow_type   flow_in,
   input  pbcp_pkg::pbcp_volt_type   volt_in,
   input  pbcp_pkg::pbcp_cur_type    cur_in,
   output pbcp_pkg::pbcp_flow_type   flow_out,
   output pbcp_pkg::pbcp_cur_type    cur_out,
   output pbcp_pkg::pbcp_pow_type    pow_out
);

   // Stage 6: voltage times current products.
   logic                                 s6_valid_ff, s6_clip_ff;
   pbcp_pkg::pbcp_cur_type               s6_cur_ff;
   logic signed [pbcp_pkg::SPROD_W-1:0]  s6_p1a_ff, s6_p1b_ff, s6_p1c_ff, s6_p1d_ff;
   logic signed [pbcp_pkg::SPROD_W-1:0]  s6_p2a_ff, s6_p2b_ff, s6_p2c_ff, s6_p2d_ff;

   // Stage 7: power sums with the rounding offset.
   logic                                 s7_valid_ff, s7_clip_ff;
   pbcp_pkg::pbcp_cur_type               s7_cur_ff;
   logic signed [pbcp_pkg::PSUM_W-1:0]   s7_s1r_ff, s7_s1i_ff, s7_s2r_ff, s7_s2i_ff;

   // Stage 8: rounded and clipped end powers.
   logic                                 s8_valid_ff, s8_clip_ff, s8_clip_in;
   pbcp_pkg::pbcp_cur_type               s8_cur_ff;
   logic [pbcp_pkg::CUR_W-1:0]           s8_s1r_ff, s8_s1i_ff, s8_s2r_ff, s8_s2i_ff;

   // Stage 9: loss and result register.
   logic                                 s9_valid_ff, s9_clip_ff, s9_clip_in;
   pbcp_pkg::pbcp_cur_type               s9_cur_ff;
   pbcp_pkg::pbcp_pow_type               s9_pow_ff, s9_pow_in;

   pbcp_pkg::pbcp_sat_type               sat_1r, sat_1i, sat_2r, sat_2i, sat_lr, sat_li;
   logic signed [pbcp_pkg::LOSS_W-1:0]   loss_re, loss_im;

   always_comb begin
      sat_1r = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(s7_s1r_ff) >>> pbcp_pkg::ROUND_SHIFT);
      sat_1i = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(s7_s1i_ff) >>> pbcp_pkg::ROUND_SHIFT);
      sat_2r = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(s7_s2r_ff) >>> pbcp_pkg::ROUND_SHIFT);
      sat_2i = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(s7_s2i_ff) >>> pbcp_pkg::ROUND_SHIFT);
      s8_clip_in = s7_clip_ff | sat_1r.clip | sat_1i.clip | sat_2r.clip | sat_2i.clip;
   end

   always_comb begin
      loss_re = pbcp_pkg::LOSS_W'($signed(s8_s1r_ff)) + pbcp_pkg::LOSS_W'($signed(s8_s2r_ff));
      loss_im = pbcp_pkg::LOSS_W'($signed(s8_s1i_ff)) + pbcp_pkg::LOSS_W'($signed(s8_s2i_ff));
      sat_lr  = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(loss_re));
      sat_li  = pbcp_pkg::sat32(pbcp_pkg::SUM_W'(loss_im));
      s9_pow_in.s1r = s8_s1r_ff;
      s9_pow_in.s1i = s8_s1i_ff;
      s9_pow_in.s2r = s8_s2r_ff;
      s9_pow_in.s2i = s8_s2i_ff;
      s9_pow_in.lr  = sat_lr.value;
      s9_pow_in.li  = sat_li.value;
      s9_clip_in    = s8_clip_ff | sat_lr.clip | sat_li.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= flow_in.valid;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // S = V * conj(I).
         s6_clip_ff <= flow_in.clip;
         s6_cur_ff  <= cur_in;
         s6_p1a_ff  <= $signed(volt_in.v1r) * $signed(cur_in.i1r);
         s6_p1b_ff  <= $signed(volt_in.v1i) * $signed(cur_in.i1i);
         s6_p1c_ff  <= $signed(volt_in.v1i) * $signed(cur_in.i1r);
         s6_p1d_ff  <= $signed(volt_in.v1r) * $signed(cur_in.i1i);
         s6_p2a_ff  <= $signed(volt_in.v2r) * $signed(cur_in.i2r);
         s6_p2b_ff  <= $signed(volt_in.v2i) * $signed(cur_in.i2i);
         s6_p2c_ff  <= $signed(volt_in.v2i) * $signed(cur_in.i2r);
         s6_p2d_ff  <= $signed(volt_in.v2r) * $signed(cur_in.i2i);

         s7_clip_ff <= s6_clip_ff;
         s7_cur_ff  <= s6_cur_ff;
         s7_s1r_ff  <= pbcp_pkg::PSUM_W'(s6_p1a_ff) + pbcp_pkg::PSUM_W'(s6_p1b_ff)
                     + pbcp_pkg::PSUM_W'(pbcp_pkg::RND_HALF);
         s7_s1i_ff  <= pbcp_pkg::PSUM_W'(s6_p1c_ff) - pbcp_pkg::PSUM_W'(s6_p1d_ff)
                     + pbcp_pkg::PSUM_W'(pbcp_pkg::RND_HALF);
         s7_s2r_ff  <= pbcp_pkg::PSUM_W'(s6_p2a_ff) + pbcp_pkg::PSUM_W'(s6_p2b_ff)
                     + pbcp_pkg::PSUM_W'(pbcp_pkg::RND_HALF);
         s7_s2i_ff  <= pbcp_pkg::PSUM_W'(s6_p2c_ff) - pbcp_pkg::PSUM_W'(s6_p2d_ff)
                     + pbcp_pkg::PSUM_W'(pbcp_pkg::RND_HALF);

         s8_clip_ff <= s8_clip_in;
         s8_cur_ff  <= s7_cur_ff;
         s8_s1r_ff  <= sat_1r.value;
         s8_s1i_ff  <= sat_1i.value;
         s8_s2r_ff  <= sat_2r.value;
         s8_s2i_ff  <= sat_2i.value;

         s9_clip_ff <= s9_clip_in;
         s9_cur_ff  <= s8_cur_ff;
         s9_pow_ff  <= s9_pow_in;
      end
   end

   assign flow_out.valid = s9_valid_ff;
   assign flow_out.clip  = s9_clip_ff;
   assign cur_out        = s9_cur_ff;
   assign pow_out        = s9_pow_ff;

endmodule

`default_nettype wire

FILE: rtl/pi_branch_current_power.sv
// Pi-model branch current and power: top level with input skid register,
// configuration registers and the two pipeline units. Depends on pbcp_pkg,
// pbcp_current, pbcp_power and pi_branch_current_power_macros.svh.
//
// For each transaction on req (the complex voltages at both ends of a line) the
// block returns one transaction on rsp with both end currents, both end powers
// and the loss, all Q16.16, and rsp_tuser high if any value was clipped. It
// takes one transaction per cycle while rsp is not stalled, and each result
// passes through the nine register stages of the current and power pipelines.
// A stall on rsp freezes the whole pipeline; one transaction that arrives
// during the stall is held in the input skid register, so req_tready comes
// from a register. Configuration writes are taken at any time (csr_ready is
// always high) and must only happen while no transaction is in flight.
`default_nettype none
`include "pi_branch_current_power_macros.svh"

module pi_branch_current_power (
   input  logic                              clock,
   input  logic                              reset,
   // from_voltage_re[15:0], from_voltage_im[31:16], to_voltage_re[47:32],
   // to_voltage_im[63:48]
   input  logic [63:0]                       req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // from_current_re[31:0], from_current_im[63:32], to_current_re[95:64],
   // to_current_im[127:96], from_power_re[159:128], from_power_im[191:160],
   // to_power_re[223:192], to_power_im[255:224], loss_re[287:256],
   // loss_im[319:288]
   output logic [319:0]                      rsp_tdata,
   // saturated
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbcp_pkg::CUR_W-1:0]        csr_data
);

   logic [pbcp_pkg::CUR_W-1:0]   series_g_ff, series_b_ff, half_shunt_ff;
   logic                         skid_valid_ff, skid_valid_in;
   pbcp_pkg::pbcp_volt_type      skid_ff;
   pbcp_pkg::pbcp_volt_type      src_volt;
   pbcp_pkg::pbcp_flow_type      src_flow;
   pbcp_pkg::pbcp_flow_type      mid_flow, out_flow;
   pbcp_pkg::pbcp_volt_type      mid_volt;
   pbcp_pkg::pbcp_cur_type       mid_cur, out_cur;
   pbcp_pkg::pbcp_pow_type       out_pow;
   logic                         en, accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_g_ff   <= '0;
         series_b_ff   <= '0;
         half_shunt_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pbcp_pkg::CSR_SERIES_G:   series_g_ff   <= csr_data;
            pbcp_pkg::CSR_SERIES_B:   series_b_ff   <= csr_data;
            pbcp_pkg::CSR_HALF_SHUNT: half_shunt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the result register is free or being read.
   assign en         = !out_flow.valid || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign src_flow.valid = skid_valid_ff || req_tvalid;
   assign src_flow.clip  = 1'b0;
   assign src_volt       = skid_valid_ff ? skid_ff : pbcp_pkg::pbcp_volt_type'(req_tdata);

   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = !en;
      end else begin
         skid_valid_in = accept && !en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !en) begin
         skid_ff <= pbcp_pkg::pbcp_volt_type'(req_tdata);
      end
   end

   pbcp_current u_current (
      .clock      (clock),
      .reset      (reset),
      .advance    (en),
      .flow_in    (src_flow),
      .volt_in    (src_volt),
      .series_g   (series_g_ff),
      .series_b   (series_b_ff),
      .half_shunt (half_shunt_ff),
      .flow_out   (mid_flow),
      .volt_out   (mid_volt),
      .cur_out    (mid_cur)
   );

   pbcp_power u_power (
      .clock    (clock),
      .reset    (reset),
      .advance  (en),
      .flow_in  (mid_flow),
      .volt_in  (mid_volt),
      .cur_in   (mid_cur),
      .flow_out (out_flow),
      .cur_out  (out_cur),
      .pow_out  (out_pow)
   );

   assign rsp_tvalid = out_flow.valid;
   assign rsp_tuser  = out_flow.clip;
   assign rsp_tdata  = {out_pow, out_cur};

   `PBCP_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid && !skid_valid_ff, "pipeline not empty after reset")
   `PBCP_ASSERT(a_skid_fill, clock, reset, $rose(skid_valid_ff) |-> !$past(en), "skid filled while pipeline moved")
   `PBCP_ASSERT(a_skid_drain, clock, reset, skid_valid_ff && en |=> !skid_valid_ff, "skid not drained")
   `PBCP_ASSERT(a_loss_re, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[287:256] == 32'(rsp_tdata[159:128] + rsp_tdata[223:192]), "active loss mismatch")
   `PBCP_ASSERT(a_loss_im, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[319:288] == 32'(rsp_tdata[191:160] + rsp_tdata[255:224]), "reactive loss mismatch")

endmodule

`default_nettype wire
